[rtl/gdcm_pkg.sv]
// types and constants shared by the gamepad drive command mapper
`timescale 1ns / 1ps
package gdcm_pkg;

  localparam int SERVO_WIDTH = 16;
  localparam int SPEED_WIDTH = 7;
  localparam int HOLD_WIDTH  = 8;
  localparam int RATE_WIDTH  = 4;
  localparam int CFG_IDX_WIDTH  = 8;
  localparam int CFG_DATA_WIDTH = 16;

  // register indexes
  localparam logic [CFG_IDX_WIDTH-1:0] REG_SPEED_MIN   = 8'd0;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_SPEED_MAX   = 8'd1;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_HOLD_TICKS  = 8'd2;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_RATE_CODE   = 8'd3;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_SERVO_A_MIN = 8'd4;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_SERVO_A_MAX = 8'd5;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_SERVO_B_MIN = 8'd6;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_SERVO_B_MAX = 8'd7;

  // reset values
  localparam logic [SPEED_WIDTH-1:0] SPEED_MIN_RST  = 7'd70;
  localparam logic [SPEED_WIDTH-1:0] SPEED_MAX_RST  = 7'd90;
  localparam logic [HOLD_WIDTH-1:0]  HOLD_TICKS_RST = 8'd2;
  localparam logic [RATE_WIDTH-1:0]  RATE_CODE_RST  = 4'd8;
  localparam logic [SPEED_WIDTH-1:0] SPEED_RST      = 7'd80;
  localparam logic [SERVO_WIDTH-1:0] SERVO_MIN_RST  = '0;
  localparam logic [SERVO_WIDTH-1:0] SERVO_MAX_RST  = '1;

  // direction patterns, bit order {right, left, down, up}
  localparam logic [3:0] DIR_UP         = 4'b0001;
  localparam logic [3:0] DIR_DOWN       = 4'b0010;
  localparam logic [3:0] DIR_LEFT       = 4'b0100;
  localparam logic [3:0] DIR_RIGHT      = 4'b1000;
  localparam logic [3:0] DIR_UP_LEFT    = 4'b0101;
  localparam logic [3:0] DIR_UP_RIGHT   = 4'b1001;
  localparam logic [3:0] DIR_DOWN_LEFT  = 4'b0110;
  localparam logic [3:0] DIR_DOWN_RIGHT = 4'b1010;

  typedef struct packed {
    logic key_up;
    logic key_down;
    logic key_left;
    logic key_right;
    logic key_faster;
    logic key_slower;
    logic key_servo_a_up;
    logic key_servo_a_down;
    logic key_servo_b_up;
    logic key_servo_b_down;
  } in_item_t;

  typedef struct packed {
    logic                   command_valid;
    logic                   left_reverse;
    logic [SPEED_WIDTH-1:0] left_speed;
    logic [RATE_WIDTH-1:0]  left_rate;
    logic                   right_reverse;
    logic [SPEED_WIDTH-1:0] right_speed;
    logic [RATE_WIDTH-1:0]  right_rate;
    logic [SERVO_WIDTH-1:0] servo_a_position;
    logic [SERVO_WIDTH-1:0] servo_b_position;
    logic                   drive_active;
  } out_item_t;

  typedef struct packed {
    logic                   command_valid;
    logic                   left_reverse;
    logic [SPEED_WIDTH-1:0] left_speed;
    logic                   right_reverse;
    logic [SPEED_WIDTH-1:0] right_speed;
    logic [RATE_WIDTH-1:0]  rate;
    logic                   drive_active;
  } wheel_cmd_t;

  typedef struct packed {
    logic [SPEED_WIDTH-1:0] speed_min;
    logic [SPEED_WIDTH-1:0] speed_max;
    logic [HOLD_WIDTH-1:0]  hold_ticks;
    logic [RATE_WIDTH-1:0]  rate_code;
    logic [SERVO_WIDTH-1:0] servo_a_min;
    logic [SERVO_WIDTH-1:0] servo_a_max;
    logic [SERVO_WIDTH-1:0] servo_b_min;
    logic [SERVO_WIDTH-1:0] servo_b_max;
  } cfg_regs_t;

endpackage

[rtl/gdcm_speed_ctrl.sv]
// hold counter and speed setting driven by the faster and slower keys
`timescale 1ns / 1ps
module gdcm_speed_ctrl (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            en,
  input  logic                            faster,
  input  logic                            slower,
  input  gdcm_pkg::cfg_regs_t             cfg,
  output logic [gdcm_pkg::SPEED_WIDTH-1:0] speed_nxt
);
  import gdcm_pkg::*;

  logic [HOLD_WIDTH-1:0]  hold_r, hold_mid, hold_nxt;
  logic [SPEED_WIDTH-1:0] speed_r, speed_mid;
  logic [SPEED_WIDTH:0]   speed_inc;

  assign speed_inc = {1'b0, speed_r} + 1'b1;

  // faster key first, then slower key on the updated count
  always_comb begin
    hold_mid  = hold_r;
    speed_mid = speed_r;
    if (faster) begin
      if (hold_r > cfg.hold_ticks) begin
        hold_mid = '0;
        if (speed_inc > {1'b0, cfg.speed_max}) begin
          speed_mid = cfg.speed_max;
        end else begin
          speed_mid = speed_inc[SPEED_WIDTH-1:0];
        end
      end else begin
        hold_mid = hold_r + 1'b1;
      end
    end
    hold_nxt  = hold_mid;
    speed_nxt = speed_mid;
    if (slower) begin
      if (hold_mid > cfg.hold_ticks) begin
        hold_nxt = '0;
        if (speed_mid > cfg.speed_min) begin
          speed_nxt = speed_mid - 1'b1;
        end
      end else begin
        hold_nxt = hold_mid + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_r  <= '0;
      speed_r <= SPEED_RST;
    end else if (en) begin
      hold_r  <= hold_nxt;
      speed_r <= speed_nxt;
    end
  end

endmodule

[rtl/gdcm_servo_step.sv]
// one servo position, stepped by one per sample within its limits
`timescale 1ns / 1ps
module gdcm_servo_step (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            en,
  input  logic                            step_up,
  input  logic                            step_down,
  input  logic [gdcm_pkg::SERVO_WIDTH-1:0] lo,
  input  logic [gdcm_pkg::SERVO_WIDTH-1:0] hi,
  output logic [gdcm_pkg::SERVO_WIDTH-1:0] value_nxt
);
  import gdcm_pkg::*;

  logic [SERVO_WIDTH-1:0] value_r, value_mid;
  logic [SERVO_WIDTH:0]   value_inc;

  assign value_inc = {1'b0, value_r} + 1'b1;

  always_comb begin
    value_mid = value_r;
    if (step_up) begin
      // saturate at the upper limit, also pulls a value above it down
      if (value_inc > {1'b0, hi}) begin
        value_mid = hi;
      end else begin
        value_mid = value_inc[SERVO_WIDTH-1:0];
      end
    end
    value_nxt = value_mid;
    if (step_down && (value_mid > lo)) begin
      value_nxt = value_mid - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      value_r <= '0;
    end else if (en) begin
      value_r <= value_nxt;
    end
  end

endmodule

[rtl/gdcm_drive_map.sv]
// direction keys to wheel command, with one stop command on release
`timescale 1ns / 1ps
module gdcm_drive_map (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            en,
  input  logic [3:0]                      dir,
  input  logic [gdcm_pkg::SPEED_WIDTH-1:0] speed,
  input  logic [gdcm_pkg::RATE_WIDTH-1:0]  rate_code,
  output gdcm_pkg::wheel_cmd_t             cmd
);
  import gdcm_pkg::*;

  logic was_pressed_r, was_pressed_nxt;
  logic any;

  assign any = |dir;

  always_comb begin
    cmd             = '0;
    was_pressed_nxt = was_pressed_r;
    cmd.drive_active = any;
    if (any) begin
      was_pressed_nxt   = 1'b1;
      cmd.command_valid = 1'b1;
      cmd.rate          = rate_code;
      case (dir)
        DIR_UP: begin
          cmd.left_speed  = speed;
          cmd.right_speed = speed;
        end
        DIR_DOWN: begin
          cmd.left_reverse  = 1'b1;
          cmd.left_speed    = speed;
          cmd.right_reverse = 1'b1;
          cmd.right_speed   = speed;
        end
        DIR_LEFT: begin
          cmd.left_reverse = 1'b1;
          cmd.left_speed   = speed;
          cmd.right_speed  = speed;
        end
        DIR_RIGHT: begin
          cmd.left_speed    = speed;
          cmd.right_reverse = 1'b1;
          cmd.right_speed   = speed;
        end
        DIR_UP_LEFT: begin
          cmd.right_speed = speed;
        end
        DIR_UP_RIGHT: begin
          cmd.left_speed = speed;
        end
        DIR_DOWN_LEFT: begin
          cmd.left_reverse  = 1'b1;
          cmd.left_speed    = speed;
          cmd.right_reverse = 1'b1;
        end
        DIR_DOWN_RIGHT: begin
          cmd.left_reverse  = 1'b1;
          cmd.right_reverse = 1'b1;
          cmd.right_speed   = speed;
        end
        // any other pattern is a stop
        default: begin
          cmd.left_speed  = '0;
          cmd.right_speed = '0;
        end
      endcase
    end else if (was_pressed_r) begin
      was_pressed_nxt   = 1'b0;
      cmd.command_valid = 1'b1;
      cmd.rate          = rate_code;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      was_pressed_r <= 1'b0;
    end else if (en) begin
      was_pressed_r <= was_pressed_nxt;
    end
  end

endmodule

[rtl/gamepad_drive_command_mapper.sv]
// top level of the gamepad drive command mapper
`timescale 1ns / 1ps
// Takes one gamepad sample per request on the in_ channel and returns one
// result per sample on the out_ channel: a wheel command (valid only when a
// direction key is held or was just released), both servo positions and the
// drive indicator. Speed and servo state advance with every sample.
// The configuration registers are written over the cfg_ channel, which is
// always ready; an index beyond the register list is ignored. Write them
// only while no request is in flight.
// A request lands in the input register, and its result is then computed
// in one pass and loaded into the output register. Throughput is one
// request per cycle while the receiver does not stall; the input register takes
// a new request while a finished result still waits in the output register.
// When the receiver stalls, one result waits at the output and one request
// in the input register, after which in_ready drops.
// Synchronous reset restores the register defaults, speed setting 80, hold
// count zero and both servo positions zero, and empties both registers.
module gamepad_drive_command_mapper (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  gdcm_pkg::in_item_t                 in_data,
  output logic                               out_valid,
  input  logic                               out_ready,
  output gdcm_pkg::out_item_t                out_data,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [gdcm_pkg::CFG_IDX_WIDTH-1:0]  cfg_index,
  input  logic [gdcm_pkg::CFG_DATA_WIDTH-1:0] cfg_data
);
  import gdcm_pkg::*;

  cfg_regs_t  cfg_r;
  in_item_t   in_item_r;
  logic       in_valid_r;
  out_item_t  out_item_r, out_item_nxt;
  logic       out_valid_r;
  logic       advance;
  logic       in_accept;

  logic [SPEED_WIDTH-1:0] speed_nxt;
  logic [SERVO_WIDTH-1:0] servo_a_nxt, servo_b_nxt;
  wheel_cmd_t             cmd;

  // the work stage moves when the output register is free or being drained
  assign advance   = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !in_valid_r || advance;
  assign in_accept = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.speed_min   <= SPEED_MIN_RST;
      cfg_r.speed_max   <= SPEED_MAX_RST;
      cfg_r.hold_ticks  <= HOLD_TICKS_RST;
      cfg_r.rate_code   <= RATE_CODE_RST;
      cfg_r.servo_a_min <= SERVO_MIN_RST;
      cfg_r.servo_a_max <= SERVO_MAX_RST;
      cfg_r.servo_b_min <= SERVO_MIN_RST;
      cfg_r.servo_b_max <= SERVO_MAX_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_SPEED_MIN:   cfg_r.speed_min   <= cfg_data[SPEED_WIDTH-1:0];
        REG_SPEED_MAX:   cfg_r.speed_max   <= cfg_data[SPEED_WIDTH-1:0];
        REG_HOLD_TICKS:  cfg_r.hold_ticks  <= cfg_data[HOLD_WIDTH-1:0];
        REG_RATE_CODE:   cfg_r.rate_code   <= cfg_data[RATE_WIDTH-1:0];
        REG_SERVO_A_MIN: cfg_r.servo_a_min <= cfg_data[SERVO_WIDTH-1:0];
        REG_SERVO_A_MAX: cfg_r.servo_a_max <= cfg_data[SERVO_WIDTH-1:0];
        REG_SERVO_B_MIN: cfg_r.servo_b_min <= cfg_data[SERVO_WIDTH-1:0];
        REG_SERVO_B_MAX: cfg_r.servo_b_max <= cfg_data[SERVO_WIDTH-1:0];
        default: begin
        end
      endcase
    end
  end

  gdcm_speed_ctrl u_speed (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (advance),
    .faster    (in_item_r.key_faster),
    .slower    (in_item_r.key_slower),
    .cfg       (cfg_r),
    .speed_nxt (speed_nxt)
  );

  gdcm_servo_step u_servo_a (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (advance),
    .step_up   (in_item_r.key_servo_a_up),
    .step_down (in_item_r.key_servo_a_down),
    .lo        (cfg_r.servo_a_min),
    .hi        (cfg_r.servo_a_max),
    .value_nxt (servo_a_nxt)
  );

  gdcm_servo_step u_servo_b (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (advance),
    .step_up   (in_item_r.key_servo_b_up),
    .step_down (in_item_r.key_servo_b_down),
    .lo        (cfg_r.servo_b_min),
    .hi        (cfg_r.servo_b_max),
    .value_nxt (servo_b_nxt)
  );

  gdcm_drive_map u_drive (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (advance),
    .dir       ({in_item_r.key_right, in_item_r.key_left,
                 in_item_r.key_down, in_item_r.key_up}),
    .speed     (speed_nxt),
    .rate_code (cfg_r.rate_code),
    .cmd       (cmd)
  );

  always_comb begin
    out_item_nxt.command_valid    = cmd.command_valid;
    out_item_nxt.left_reverse     = cmd.left_reverse;
    out_item_nxt.left_speed       = cmd.left_speed;
    out_item_nxt.left_rate        = cmd.rate;
    out_item_nxt.right_reverse    = cmd.right_reverse;
    out_item_nxt.right_speed      = cmd.right_speed;
    out_item_nxt.right_rate       = cmd.rate;
    out_item_nxt.servo_a_position = servo_a_nxt;
    out_item_nxt.servo_b_position = servo_b_nxt;
    out_item_nxt.drive_active     = cmd.drive_active;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_ready) begin
        in_valid_r <= in_valid;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      in_item_r <= in_data;
    end
    if (advance) begin
      out_item_r <= out_item_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_item_r;

endmodule
